FILE: sv/gcs_pkg.sv
// shared types and constants for the gain and clipping sample chain
`timescale 1ns / 1ps
package gcs_pkg;

  localparam int V_W    = 32;
  localparam int ROOT_W = 20;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NCELL  = ROOT_W;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_LEVEL = 2'd2;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_HARD = 2'd1;
  localparam logic [1:0] MODE_SOFT = 2'd2;

  typedef enum logic [1:0] {
    KIND_KEEP,
    KIND_POS,
    KIND_NEG
  } gcs_kind_t;

  typedef struct packed {
    gcs_kind_t               kind;
    logic signed [V_W-1:0]   val;
    logic                    flag;
  } gcs_side_t;

  typedef struct packed {
    gcs_side_t               side;
    logic [RAD_W-1:0]        rad;
    logic [ROOT_W-1:0]       root;
    logic [REM_W-1:0]        rem;
  } gcs_cell_t;

endpackage

FILE: sv/gcs_front.sv
// centring, gain multiply and clip decision stages
`timescale 1ns / 1ps
module gcs_front #(
  parameter int HALF_RANGE = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          sample,
  input  logic [15:0]         gain,
  input  logic [1:0]          mode,
  input  logic [14:0]         lvl,
  output logic                out_valid,
  input  logic                out_ready,
  output gcs_pkg::gcs_cell_t  out_cell
);
  import gcs_pkg::*;

  localparam logic signed [16:0] HALF = 17'(HALF_RANGE);

  logic                  va_r, vb_r;
  logic                  ready_a, ready_b;
  logic signed [V_W-1:0] v_a_r;
  logic signed [16:0]    s;
  logic signed [33:0]    prod;
  logic signed [V_W-1:0] lvl_s, neg_lvl, exc;
  logic                  hi, lo;
  gcs_cell_t             cell_nxt, cell_r;

  assign ready_b  = !vb_r || out_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  assign s    = signed'({9'd0, sample}) - HALF;
  assign prod = s * signed'({1'b0, gain});

  assign lvl_s   = signed'({17'd0, lvl});
  assign neg_lvl = -lvl_s;
  assign hi      = v_a_r > lvl_s;
  assign lo      = v_a_r < neg_lvl;
  assign exc     = hi ? (v_a_r - lvl_s) : (neg_lvl - v_a_r);

  always_comb begin
    cell_nxt.side.kind = KIND_KEEP;
    cell_nxt.side.val  = v_a_r;
    cell_nxt.side.flag = 1'b0;
    cell_nxt.rad       = {1'b0, exc[V_W-2:0], 8'd0};
    cell_nxt.root      = '0;
    cell_nxt.rem       = '0;
    unique case (mode)
      MODE_HARD: begin
        if (hi) begin
          cell_nxt.side.val  = lvl_s;
          cell_nxt.side.flag = 1'b1;
        end else if (lo) begin
          cell_nxt.side.val  = neg_lvl;
          cell_nxt.side.flag = 1'b1;
        end
      end
      MODE_SOFT: begin
        if (hi) begin
          cell_nxt.side.kind = KIND_POS;
        end else if (lo) begin
          cell_nxt.side.kind = KIND_NEG;
        end
      end
      default: begin
        cell_nxt.side.kind = KIND_KEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) v_a_r <= prod[V_W-1:0];
    if (ready_b && va_r) cell_r <= cell_nxt;
  end

  assign out_valid = vb_r;
  assign out_cell  = cell_r;

endmodule

FILE: sv/gcs_sqrt_cell.sv
// one root digit cell of the soft clip square root chain
`timescale 1ns / 1ps
module gcs_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcs_pkg::gcs_cell_t  in_cell,
  output logic                out_valid,
  input  logic                out_ready,
  output gcs_pkg::gcs_cell_t  out_cell
);
  import gcs_pkg::*;

  logic               valid_r;
  logic [REM_W+1:0]   rem_t;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;
  logic               ge;
  gcs_cell_t          cell_nxt, cell_r;

  assign in_ready = !valid_r || out_ready;

  assign rem_t = {in_cell.rem, in_cell.rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, in_cell.root, 2'b01};
  assign ge    = rem_t >= trial;
  assign diff  = rem_t - trial;

  always_comb begin
    cell_nxt.side = in_cell.side;
    cell_nxt.rad  = {in_cell.rad[RAD_W-3:0], 2'b00};
    cell_nxt.root = {in_cell.root[ROOT_W-2:0], ge};
    cell_nxt.rem  = ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) cell_r <= cell_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

FILE: sv/gcs_back.sv
// soft clip result, final clamp, re-bias and output register
`timescale 1ns / 1ps
module gcs_back #(
  parameter int HALF_RANGE = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcs_pkg::gcs_cell_t  in_cell,
  input  logic [14:0]         lvl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          sample_out,
  output logic                clipped
);
  import gcs_pkg::*;

  localparam logic signed [V_W-1:0] LIM = V_W'(HALF_RANGE * 256);
  localparam logic signed [V_W-1:0] RND = V_W'(128);

  logic                  vc_r, vd_r;
  logic                  ready_c, ready_d;
  logic signed [V_W-1:0] mag, vsoft, vclip_nxt, vclip_r;
  logic                  clip_c_nxt, clip_c_r;
  logic signed [V_W-1:0] vlim;
  logic                  clip_d_nxt;
  logic signed [V_W-1:0] sum;
  logic [7:0]            sample_r;
  logic                  clipped_r;

  assign ready_d  = !vd_r || out_ready;
  assign ready_c  = !vc_r || ready_d;
  assign in_ready = ready_c;

  assign mag   = signed'({17'd0, lvl}) + signed'({12'd0, in_cell.root});
  assign vsoft = (in_cell.side.kind == KIND_NEG) ? -mag : mag;

  always_comb begin
    if (in_cell.side.kind == KIND_KEEP) begin
      vclip_nxt  = in_cell.side.val;
      clip_c_nxt = in_cell.side.flag;
    end else begin
      vclip_nxt  = vsoft;
      clip_c_nxt = vsoft != in_cell.side.val;
    end
  end

  always_comb begin
    vlim       = vclip_r;
    clip_d_nxt = clip_c_r;
    if (vclip_r > LIM) begin
      vlim       = LIM;
      clip_d_nxt = 1'b1;
    end else if (vclip_r < -LIM) begin
      vlim       = -LIM;
      clip_d_nxt = 1'b1;
    end
  end

  assign sum = vlim + LIM + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ready_c) vc_r <= in_valid;
      if (ready_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && in_valid) begin
      vclip_r  <= vclip_nxt;
      clip_c_r <= clip_c_nxt;
    end
    if (ready_d && vc_r) begin
      sample_r  <= sum[15:8];
      clipped_r <= clip_d_nxt;
    end
  end

  assign out_valid  = vd_r;
  assign sample_out = sample_r;
  assign clipped    = clipped_r;

endmodule

FILE: sv/gain_and_clipping_sample_chain.sv
// top level of the gain and clipping sample chain
`timescale 1ns / 1ps
// Each request carries one biased 8-bit sample. It is centred, scaled by the
// Q8.8 gain, passed, hard clipped or soft clipped (level plus square root of
// the excess), clamped to the half range and re-biased with round half up.
// One sample is taken per clock while the output is not stalled. The path runs
// through two front stages, twenty root cells that each settle one bit of
// the square root, and two back stages ending in the output register. Every
// stage holds its own valid bit, so gaps close up under back-pressure.
// Registers: index 0 gain, 1 clip mode, 2 clip level; write only while idle.
module gain_and_clipping_sample_chain #(
  parameter int HALF_RANGE = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] sample_out
  output logic [0:0]  out_tuser,  // [0] clipped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import gcs_pkg::*;

  logic [15:0] gain_r;
  logic [1:0]  mode_r;
  logic [14:0] lvl_r;

  logic      vld [0:NCELL];
  logic      rdy [0:NCELL];
  gcs_cell_t chain_cell [0:NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd256;
      mode_r <= MODE_PASS;
      lvl_r  <= 15'd32512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:  gain_r <= cfg_wdata;
        REG_MODE:  mode_r <= cfg_wdata[1:0];
        REG_LEVEL: lvl_r  <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  gcs_front #(
    .HALF_RANGE(HALF_RANGE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .sample    (in_tdata),
    .gain      (gain_r),
    .mode      (mode_r),
    .lvl       (lvl_r),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_cell  (chain_cell[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gcs_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_cell   (chain_cell[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_cell  (chain_cell[i+1])
    );
  end

  gcs_back #(
    .HALF_RANGE(HALF_RANGE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vld[NCELL]),
    .in_ready   (rdy[NCELL]),
    .in_cell    (chain_cell[NCELL]),
    .lvl        (lvl_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .sample_out (out_tdata),
    .clipped    (out_tuser[0])
  );

  // an empty output register frees the whole chain
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output register empty");

  // root remainder bound at the end of the chain
  a_root_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NCELL] |->
      ({1'b0, chain_cell[NCELL].rem} <= {2'b00, chain_cell[NCELL].root, 1'b0}))
    else $error("square root remainder out of range");

  // a stalled root result keeps its value
  a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NCELL] && !rdy[NCELL] |=> vld[NCELL] && $stable(chain_cell[NCELL].root))
    else $error("stalled root result changed");

endmodule
